>>> src/tilemap_block_copy_splitter_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef TILEMAP_BLOCK_COPY_SPLITTER_MACROS_SVH
`define TILEMAP_BLOCK_COPY_SPLITTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TBCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbcs: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TBCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbcs: next-cycle check failed");

`endif

>>> src/tbcs_pkg.sv
package tbcs_pkg;

	localparam int VIEW_COLS     = 33;
	localparam int VIEW_ROWS     = 25;
	localparam int BLOCK_TILES   = 32;
	localparam int MAP_MAX_TILES = 2 * BLOCK_TILES;
	// byte offset of the top right block of a map that is both wide and tall
	localparam int BLOCK_BYTES   = 2 * BLOCK_TILES * BLOCK_TILES;
	// bytes per map tile line of one block (two bytes per tile)
	localparam int LINE_BYTES    = 2 * BLOCK_TILES;
	localparam int CMD_MAX       = 4;

	typedef enum logic [1:0] {
		REG_MAP_WIDTH    = 2'd0,
		REG_MAP_HEIGHT   = 2'd1,
		REG_TARGET_LAYER = 2'd2
	} cfg_reg_t;

	// One copy command; dest_col sits in the lowest bits.
	typedef struct packed {
		logic [5:0]  block_height;
		logic [5:0]  block_width;
		logic [4:0]  src_row;
		logic [4:0]  src_col;
		logic [12:0] block_offset;
		logic [5:0]  rect_height;
		logic [5:0]  rect_width;
		logic [4:0]  dest_row;
		logic [5:0]  dest_col;
	} cmd_t;

endpackage

>>> src/tbcs_cmd_gen.sv
// Clips the view against the map and splits the rectangle at block
// boundaries. Pure combinational; at most two chunks per direction.
module tbcs_cmd_gen import tbcs_pkg::*; (
	input  logic signed [7:0] shift_x,
	input  logic signed [7:0] shift_y,
	input  logic [6:0]        map_w,
	input  logic [6:0]        map_h,
	output cmd_t              cmds [CMD_MAX],
	output logic [2:0]        count
);

	logic [6:0]        mw, mh;
	logic [6:0]        dx, dy;
	logic [7:0]        skx, sky;
	logic signed [8:0] wa, wb, wc, ha, hb, hc;
	logic              nonempty;
	logic [5:0]        w, h;
	logic [4:0]        cin0, rin0;
	logic              fits_x, fits_y, split_x, split_y;
	logic [5:0]        cch0, cch1, rch0, rch1;
	logic [5:0]        dcol1;
	logic [4:0]        drow1;
	logic              wide, tall;
	logic [5:0]        bw_lo, bw_hi, bh_lo, bh_hi;
	logic [12:0]       mw64, mh64;

	function automatic logic [12:0] blk_offset(input logic bx, input logic by,
		input logic is_wide, input logic is_tall,
		input logic [12:0] w64, input logic [12:0] h64);
		logic [12:0] off;
		unique case ({is_wide, is_tall})
			2'b00: off = 13'd0;
			2'b10: off = bx ? h64 : 13'd0;
			2'b01: off = by ? w64 : 13'd0;
			2'b11: begin
				if (!by)
					off = bx ? 13'(BLOCK_BYTES) : 13'd0;
				else
					off = w64 + (bx ? h64 : 13'd0);
			end
			default: off = 13'd0;
		endcase
		return off;
	endfunction

	// saturate map size
	assign mw = (map_w > 7'(MAP_MAX_TILES)) ? 7'(MAP_MAX_TILES) : map_w;
	assign mh = (map_h > 7'(MAP_MAX_TILES)) ? 7'(MAP_MAX_TILES) : map_h;

	// destination start and source skip
	assign dx  = shift_x[7] ? 7'd0 : shift_x[6:0];
	assign dy  = shift_y[7] ? 7'd0 : shift_y[6:0];
	assign skx = shift_x[7] ? (~shift_x + 8'd1) : 8'd0;
	assign sky = shift_y[7] ? (~shift_y + 8'd1) : 8'd0;

	// clip: min of view remainder and map remainder
	assign wa = 9'(VIEW_COLS) - {2'b00, dx};
	assign wb = {2'b00, mw} - {1'b0, skx};
	assign wc = (wa < wb) ? wa : wb;
	assign ha = 9'(VIEW_ROWS) - {2'b00, dy};
	assign hb = {2'b00, mh} - {1'b0, sky};
	assign hc = (ha < hb) ? ha : hb;
	assign nonempty = (wc > 9'sd0) && (hc > 9'sd0);
	assign w = wc[5:0];
	assign h = hc[5:0];

	// column chunks
	assign cin0    = skx[4:0];
	assign fits_x  = ({2'b00, cin0} + {1'b0, w}) <= 7'(BLOCK_TILES);
	assign cch0    = fits_x ? w : 6'(BLOCK_TILES) - {1'b0, cin0};
	assign cch1    = w - cch0;
	assign split_x = !fits_x;
	assign dcol1   = dx[5:0] + cch0;

	// row chunks
	assign rin0    = sky[4:0];
	assign fits_y  = ({2'b00, rin0} + {1'b0, h}) <= 7'(BLOCK_TILES);
	assign rch0    = fits_y ? h : 6'(BLOCK_TILES) - {1'b0, rin0};
	assign rch1    = h - rch0;
	assign split_y = !fits_y;
	assign drow1   = 5'({1'b0, dy[4:0]} + rch0);

	// block geometry
	assign wide  = mw > 7'(BLOCK_TILES);
	assign tall  = mh > 7'(BLOCK_TILES);
	assign bw_lo = wide ? 6'(BLOCK_TILES) : mw[5:0];
	assign bw_hi = 6'(mw - 7'(BLOCK_TILES));
	assign bh_lo = tall ? 6'(BLOCK_TILES) : mh[5:0];
	assign bh_hi = 6'(mh - 7'(BLOCK_TILES));
	assign mw64  = 13'(mw) * 13'(LINE_BYTES);
	assign mh64  = 13'(mh) * 13'(LINE_BYTES);

	// command slots: rows top to bottom, columns left to right
	always_comb begin
		logic [1:0] k;
		logic       rsel, csel, bx, by;
		for (int i = 0; i < CMD_MAX; i++) begin
			k    = 2'(i);
			rsel = split_x ? k[1] : k[0];
			csel = split_x ? k[0] : 1'b0;
			bx   = csel | skx[5];
			by   = rsel | sky[5];
			cmds[i].dest_col     = csel ? dcol1 : dx[5:0];
			cmds[i].dest_row     = rsel ? drow1 : dy[4:0];
			cmds[i].rect_width   = csel ? cch1 : cch0;
			cmds[i].rect_height  = rsel ? rch1 : rch0;
			cmds[i].src_col      = csel ? 5'd0 : cin0;
			cmds[i].src_row      = rsel ? 5'd0 : rin0;
			cmds[i].block_width  = bx ? bw_hi : bw_lo;
			cmds[i].block_height = by ? bh_hi : bh_lo;
			cmds[i].block_offset = blk_offset(bx, by, wide, tall, mw64, mh64);
		end
	end

	always_comb begin
		if (!nonempty)
			count = 3'd0;
		else if (split_x && split_y)
			count = 3'd4;
		else if (split_x || split_y)
			count = 3'd2;
		else
			count = 3'd1;
	end

endmodule

>>> src/tilemap_block_copy_splitter.sv
// Tile map block copy splitter. Each input word carries a signed tile shift; the block
// clips the 33x25-tile view against the source map and emits zero to four copy commands,
// split at 32x32-tile block boundaries, rows of blocks top to bottom and left to right
// within a row; tlast marks the final command of an input. A shift is registered, and from
// that register all its commands load at once into a four-entry command queue that drains
// one command per cycle on the output port while m_tready is high. An input gives up to
// four commands; a new input is taken every cycle while the queue keeps up, and the next
// input's commands follow the previous last command with no gap. An empty clip passes the
// input register and gives no output. Map width and height are written at cfg index 0 and
// 1 (values above 64 act as 64); index 2, the target layer, is accepted and has no effect
// on the commands. Write configuration only while the block is idle.
`include "tilemap_block_copy_splitter_macros.svh"

module tilemap_block_copy_splitter import tbcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	// shift input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // shift_x[7:0], shift_y[15:8]
	// copy command output
	output logic        m_tvalid,
	input  logic        m_tready,
	// dest_col[5:0], dest_row[10:6], rect_width[16:11], rect_height[22:17],
	// block_offset[35:23], src_col[40:36], src_row[45:41], block_width[51:46],
	// block_height[57:52], zero[63:58]
	output logic [63:0] m_tdata,
	output logic        m_tlast
);

	logic [6:0]        map_w_q, map_h_q;
	logic              in_valid_s1;
	logic signed [7:0] sx_s1, sy_s1;
	cmd_t              gen_cmds [CMD_MAX];
	logic [2:0]        gen_count;
	cmd_t              cmd_q [CMD_MAX];
	logic [2:0]        cnt_q;
	logic [1:0]        idx_q;
	logic              load;

	// configuration registers; the layer select needs no storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= 7'(BLOCK_TILES);
			map_h_q <= 7'(BLOCK_TILES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:  map_w_q <= cfg_data;
				REG_MAP_HEIGHT: map_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// queue takes new commands when empty or when its last word leaves now
	assign load     = in_valid_s1 && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_tready));
	assign s_tready = !in_valid_s1 || load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_tvalid && s_tready)
			in_valid_s1 <= 1'b1;
		else if (load)
			in_valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sx_s1 <= s_tdata[7:0];
			sy_s1 <= s_tdata[15:8];
		end
	end

	tbcs_cmd_gen u_gen (
		.shift_x (sx_s1),
		.shift_y (sy_s1),
		.map_w   (map_w_q),
		.map_h   (map_h_q),
		.cmds    (gen_cmds),
		.count   (gen_count)
	);

	// command queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= gen_count;
			idx_q <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			cmd_q <= gen_cmds;
	end

	assign m_tvalid = cnt_q != 3'd0;
	assign m_tlast  = cnt_q == 3'd1;
	assign m_tdata  = {6'd0, cmd_q[idx_q]};

	`TBCS_ASSERT_NEXT(a_in_capture, s_tvalid && s_tready, in_valid_s1)
	`TBCS_ASSERT_NEXT(a_drain_step, m_tvalid && m_tready && (cnt_q > 3'd1),
		m_tvalid && (idx_q == $past(idx_q) + 2'd1))
	`TBCS_ASSERT_NEXT(a_last_empties, m_tvalid && m_tready && m_tlast && !in_valid_s1,
		!m_tvalid)
	`TBCS_ASSERT_NOW(a_rect_nonzero, m_tvalid,
		(m_tdata[16:11] != 6'd0) && (m_tdata[22:17] != 6'd0))

endmodule
